// ===== rtl/sst_pkg.sv =====
// Shared types, codes and keyword table for the source tokenizer.
package sst_pkg;

   localparam int PosWidth = 21;
   localparam int NumKeywords = 30;
   localparam int MaxKeywordLength = 12;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_INT    = 3'd2,
      MODE_INTDOT = 3'd3,
      MODE_FRAC   = 3'd4,
      MODE_STRING = 3'd5,
      MODE_OPER   = 3'd6,
      MODE_ERROR  = 3'd7
   } scan_mode_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_MINUS = 3'd1,
      OP_EQ    = 3'd2,
      OP_BANG  = 3'd3,
      OP_LT    = 3'd4,
      OP_GT    = 3'd5,
      OP_COLON = 3'd6
   } pending_op_type;

   localparam logic [5:0] KIND_IDENT  = 6'd0;
   localparam logic [5:0] KIND_INT    = 6'd1;
   localparam logic [5:0] KIND_DEC    = 6'd2;
   localparam logic [5:0] KIND_STR    = 6'd3;
   localparam logic [5:0] KIND_KW0    = 6'd4;
   localparam logic [5:0] KIND_PLUS   = 6'd34;
   localparam logic [5:0] KIND_MINUS  = 6'd35;
   localparam logic [5:0] KIND_ARROW  = 6'd36;
   localparam logic [5:0] KIND_STAR   = 6'd37;
   localparam logic [5:0] KIND_SLASH  = 6'd38;
   localparam logic [5:0] KIND_ASSIGN = 6'd39;
   localparam logic [5:0] KIND_EQEQ   = 6'd40;
   localparam logic [5:0] KIND_NE     = 6'd41;
   localparam logic [5:0] KIND_LT     = 6'd42;
   localparam logic [5:0] KIND_LE     = 6'd43;
   localparam logic [5:0] KIND_GT     = 6'd44;
   localparam logic [5:0] KIND_GE     = 6'd45;
   localparam logic [5:0] KIND_COLON  = 6'd46;
   localparam logic [5:0] KIND_SCOPE  = 6'd47;
   localparam logic [5:0] KIND_DEFINE = 6'd48;
   localparam logic [5:0] KIND_LPAREN = 6'd49;
   localparam logic [5:0] KIND_RPAREN = 6'd50;
   localparam logic [5:0] KIND_LBRACE = 6'd51;
   localparam logic [5:0] KIND_RBRACE = 6'd52;
   localparam logic [5:0] KIND_LBRACK = 6'd53;
   localparam logic [5:0] KIND_RBRACK = 6'd54;
   localparam logic [5:0] KIND_COMMA  = 6'd55;
   localparam logic [5:0] KIND_DOT    = 6'd56;
   localparam logic [5:0] KIND_QUEST  = 6'd57;
   localparam logic [5:0] KIND_EOF    = 6'd58;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_INVALID  = 2'd1;
   localparam logic [1:0] ERR_UNTERM   = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG = 2'd3;

   typedef struct packed {
      logic [5:0]          token_kind;
      logic [1:0]          error_code;
      logic [PosWidth-1:0] text_offset;
      logic [PosWidth-1:0] text_length;
      logic [PosWidth-1:0] start_line;
      logic [PosWidth-1:0] start_column;
      logic                last_of_run;
   } token_type;

   typedef logic [8*MaxKeywordLength-1:0] kw_text_type;

   // Keyword text, first character in the top byte, zero padded.
   function automatic kw_text_type kw_text(input int idx);
      kw_text_type t;
      t = '0;
      case (idx)
         0:  t = {"function", 32'd0};
         1:  t = {"return", 48'd0};
         2:  t = {"if", 80'd0};
         3:  t = {"else", 64'd0};
         4:  t = {"while", 56'd0};
         5:  t = {"for", 72'd0};
         6:  t = {"in", 80'd0};
         7:  t = {"stop", 64'd0};
         8:  t = {"continue", 32'd0};
         9:  t = {"handle", 48'd0};
         10: t = {"public", 48'd0};
         11: t = {"private", 40'd0};
         12: t = {"class", 56'd0};
         13: t = {"struct", 48'd0};
         14: t = {"enum", 64'd0};
         15: t = {"interface", 24'd0};
         16: t = {"virtual", 40'd0};
         17: t = {"override", 32'd0};
         18: t = {"abstract", 32'd0};
         19: t = {"implements", 16'd0};
         20: t = {"overload", 32'd0};
         21: t = {"true", 64'd0};
         22: t = {"false", 56'd0};
         23: t = {"null", 64'd0};
         24: t = {"self", 64'd0};
         25: t = {"and", 72'd0};
         26: t = {"or", 80'd0};
         27: t = {"as", 80'd0};
         28: t = {"weak", 64'd0};
         29: t = {"performance", 8'd0};
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] kw_char(input int idx, input logic [3:0] pos);
      kw_text_type t;
      logic [7:0] c;
      t = kw_text(idx);
      c = 8'd0;
      if (pos < 4'(MaxKeywordLength)) begin
         c = t[8*(MaxKeywordLength-1-int'(pos)) +: 8];
      end
      return c;
   endfunction

endpackage

// ===== rtl/script_source_tokenizer_unit.sv =====
// Top level of the streaming source tokenizer.
// The tokenizer takes one source byte or end marker per cycle and emits up to three
// tokens for it through a four-entry result queue. A byte is taken in the cycle it is
// offered while the queue holds at most one waiting token, so a stream of bytes runs at
// one per cycle as long as the result side keeps up; a byte that closes two tokens and
// starts a third holds the input while the queue drains. Reported offsets, lengths,
// lines and columns are 21 bits wide and wrap there; a byte at offset MaxSourceBytes is
// reported as an overlong source.
module script_source_tokenizer_unit #(
   parameter longint MaxSourceBytes = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_code,
   output logic [20:0] rsp_text_offset,
   output logic [20:0] rsp_text_length,
   output logic [20:0] rsp_start_line,
   output logic [20:0] rsp_start_column,
   output logic        rsp_last_of_run
);

   logic grp_valid, grp_stall;
   logic [1:0] grp_count;
   sst_pkg::token_type grp_tok [3];
   sst_pkg::token_type out_tok;

   sst_scanner #(.MaxSourceBytes(MaxSourceBytes)) u_scanner (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall),
      .in_end(req_type), .in_byte(req_char_byte),
      .grp_valid(grp_valid), .grp_stall(grp_stall),
      .grp_count(grp_count), .grp_tok(grp_tok)
   );

   sst_token_queue u_queue (
      .clock(clock), .reset(reset),
      .grp_valid(grp_valid), .grp_stall(grp_stall),
      .grp_count(grp_count), .grp_tok(grp_tok),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_tok(out_tok)
   );

   assign rsp_token_kind = out_tok.token_kind;
   assign rsp_error_code = out_tok.error_code;
   assign rsp_text_offset = out_tok.text_offset;
   assign rsp_text_length = out_tok.text_length;
   assign rsp_start_line = out_tok.start_line;
   assign rsp_start_column = out_tok.start_column;
   assign rsp_last_of_run = out_tok.last_of_run;

endmodule

// ===== rtl/sst_scanner.sv =====
// Front part: scanner state machine that classifies bytes and builds result groups.
module sst_scanner #(
   parameter longint MaxSourceBytes = 1048576
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic                  in_end,
   input  logic [7:0]            in_byte,
   output logic                  grp_valid,
   input  logic                  grp_stall,
   output logic [1:0]            grp_count,
   output sst_pkg::token_type    grp_tok [3]
);

   localparam int PW = sst_pkg::PosWidth;
   // The byte counter is wide enough for the largest allowed source limit.
   localparam int CW = 33;
   localparam logic [CW-1:0] MaxPos = CW'(MaxSourceBytes);

   sst_pkg::scan_mode_type  mode_ff, mode_in;
   sst_pkg::pending_op_type op_ff, op_in;
   logic [PW-1:0] tstart_ff, tstart_in;
   logic [PW-1:0] tline_ff, tline_in;
   logic [PW-1:0] tcol_ff, tcol_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [PW-1:0] line_ff, line_in;
   logic [PW-1:0] col_ff, col_in;
   logic [sst_pkg::NumKeywords-1:0] cand_ff, cand_in;
   logic [3:0]    idlen_ff, idlen_in;

   sst_pkg::token_type t [3];
   logic [1:0] n;

   logic fire;
   assign in_stall = grp_stall;
   assign fire = in_valid && !grp_stall;
   assign grp_valid = fire && (n != 2'd0);
   assign grp_count = n;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic logic is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   logic [5:0] kw_hit;
   logic [sst_pkg::NumKeywords-1:0] cand_upd;

   always_comb begin
      kw_hit = sst_pkg::KIND_IDENT;
      if (idlen_ff < 4'(sst_pkg::MaxKeywordLength)) begin
         for (int k = sst_pkg::NumKeywords - 1; k >= 0; k--) begin
            if (cand_ff[k] && sst_pkg::kw_char(k, idlen_ff) == 8'd0) begin
               kw_hit = sst_pkg::KIND_KW0 + 6'(k);
            end
         end
      end
   end

   // Candidate mask after matching this byte; base is the mask in use.
   function automatic logic [sst_pkg::NumKeywords-1:0] kw_next(
      input logic [sst_pkg::NumKeywords-1:0] base, input logic [3:0] len,
      input logic [7:0] c);
      logic [sst_pkg::NumKeywords-1:0] r;
      r = base;
      for (int k = 0; k < sst_pkg::NumKeywords; k++) begin
         if (len >= 4'(sst_pkg::MaxKeywordLength) || sst_pkg::kw_char(k, len) != c) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic sst_pkg::token_type mk(input logic [5:0] kind, input logic [1:0] err,
      input logic [PW-1:0] off, input logic [PW-1:0] len, input logic [PW-1:0] ln,
      input logic [PW-1:0] cl);
      sst_pkg::token_type r;
      r.token_kind = kind;
      r.error_code = err;
      r.text_offset = off;
      r.text_length = len;
      r.start_line = ln;
      r.start_column = cl;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [PW-1:0] p;
      logic          rescan;
      logic [5:0]    pk;
      logic [5:0]    single;
      sst_pkg::pending_op_type sop;
      logic [5:0]    opk;
      logic [7:0]    c;
      mode_in = mode_ff;
      op_in = op_ff;
      tstart_in = tstart_ff;
      tline_in = tline_ff;
      tcol_in = tcol_ff;
      pos_in = pos_ff;
      line_in = line_ff;
      col_in = col_ff;
      cand_in = cand_ff;
      idlen_in = idlen_ff;
      n = 2'd0;
      for (int i = 0; i < 3; i++) begin
         t[i] = '0;
      end
      c = in_byte;
      p = pos_ff[PW-1:0];
      rescan = 1'b0;
      pk = 6'd0;
      single = 6'd0;
      sop = sst_pkg::OP_NONE;
      unique case (op_ff)
         sst_pkg::OP_MINUS: opk = sst_pkg::KIND_MINUS;
         sst_pkg::OP_EQ:    opk = sst_pkg::KIND_ASSIGN;
         sst_pkg::OP_LT:    opk = sst_pkg::KIND_LT;
         sst_pkg::OP_GT:    opk = sst_pkg::KIND_GT;
         default:           opk = sst_pkg::KIND_COLON;
      endcase
      if (in_valid) begin
         if (in_end) begin
            if (mode_ff == sst_pkg::MODE_STRING) begin
               t[0] = mk(6'd0, sst_pkg::ERR_UNTERM, tstart_ff, p - tstart_ff, tline_ff,
                         tcol_ff);
               n = 2'd1;
            end else if (mode_ff == sst_pkg::MODE_OPER && op_ff == sst_pkg::OP_BANG) begin
               t[0] = mk(6'd0, sst_pkg::ERR_INVALID, tstart_ff, PW'(1), tline_ff, tcol_ff);
               n = 2'd1;
            end else if (mode_ff != sst_pkg::MODE_ERROR) begin
               unique case (mode_ff)
                  sst_pkg::MODE_IDENT: begin
                     t[0] = mk(kw_hit, sst_pkg::ERR_NONE, tstart_ff, p - tstart_ff,
                               tline_ff, tcol_ff);
                     n = 2'd1;
                  end
                  sst_pkg::MODE_INT: begin
                     t[0] = mk(sst_pkg::KIND_INT, sst_pkg::ERR_NONE, tstart_ff,
                               p - tstart_ff, tline_ff, tcol_ff);
                     n = 2'd1;
                  end
                  sst_pkg::MODE_INTDOT: begin
                     t[0] = mk(sst_pkg::KIND_INT, sst_pkg::ERR_NONE, tstart_ff,
                               p - tstart_ff - PW'(1), tline_ff, tcol_ff);
                     t[1] = mk(sst_pkg::KIND_DOT, sst_pkg::ERR_NONE, p - PW'(1), PW'(1),
                               line_ff, col_ff - PW'(1));
                     n = 2'd2;
                  end
                  sst_pkg::MODE_FRAC: begin
                     t[0] = mk(sst_pkg::KIND_DEC, sst_pkg::ERR_NONE, tstart_ff,
                               p - tstart_ff, tline_ff, tcol_ff);
                     n = 2'd1;
                  end
                  sst_pkg::MODE_OPER: begin
                     t[0] = mk(opk, sst_pkg::ERR_NONE, tstart_ff, p - tstart_ff,
                               tline_ff, tcol_ff);
                     n = 2'd1;
                  end
                  default: n = 2'd0;
               endcase
               t[n] = mk(sst_pkg::KIND_EOF, sst_pkg::ERR_NONE, p, PW'(0), line_ff, col_ff);
               n = n + 2'd1;
            end
            mode_in = sst_pkg::MODE_IDLE;
            op_in = sst_pkg::OP_NONE;
            tstart_in = '0;
            tline_in = PW'(1);
            tcol_in = PW'(1);
            pos_in = '0;
            line_in = PW'(1);
            col_in = PW'(1);
            cand_in = '1;
            idlen_in = '0;
         end else if (mode_ff == sst_pkg::MODE_ERROR) begin
            n = 2'd0;
         end else if (pos_ff >= MaxPos) begin
            t[0] = mk(6'd0, sst_pkg::ERR_TOO_LONG, MaxPos[PW-1:0], PW'(0), line_ff, col_ff);
            n = 2'd1;
            mode_in = sst_pkg::MODE_ERROR;
         end else begin
            // Continue the current token where the byte extends it.
            unique case (mode_ff)
               sst_pkg::MODE_IDENT: begin
                  if (is_alpha(c) || is_numeral(c) || c == "_") begin
                     cand_in = kw_next(cand_ff, idlen_ff, c);
                     if (idlen_ff < 4'(sst_pkg::MaxKeywordLength)) idlen_in = idlen_ff + 4'd1;
                  end else begin
                     rescan = 1'b1;
                     t[0] = mk(kw_hit, sst_pkg::ERR_NONE, tstart_ff, p - tstart_ff,
                               tline_ff, tcol_ff);
                     n = 2'd1;
                  end
               end
               sst_pkg::MODE_INT: begin
                  if (c == ".") begin
                     mode_in = sst_pkg::MODE_INTDOT;
                  end else if (!is_numeral(c)) begin
                     rescan = 1'b1;
                     t[0] = mk(sst_pkg::KIND_INT, sst_pkg::ERR_NONE, tstart_ff,
                               p - tstart_ff, tline_ff, tcol_ff);
                     n = 2'd1;
                  end
               end
               sst_pkg::MODE_INTDOT: begin
                  if (is_numeral(c)) begin
                     mode_in = sst_pkg::MODE_FRAC;
                  end else begin
                     rescan = 1'b1;
                     t[0] = mk(sst_pkg::KIND_INT, sst_pkg::ERR_NONE, tstart_ff,
                               p - tstart_ff - PW'(1), tline_ff, tcol_ff);
                     t[1] = mk(sst_pkg::KIND_DOT, sst_pkg::ERR_NONE, p - PW'(1), PW'(1),
                               line_ff, col_ff - PW'(1));
                     n = 2'd2;
                  end
               end
               sst_pkg::MODE_FRAC: begin
                  if (!is_numeral(c)) begin
                     rescan = 1'b1;
                     t[0] = mk(sst_pkg::KIND_DEC, sst_pkg::ERR_NONE, tstart_ff,
                               p - tstart_ff, tline_ff, tcol_ff);
                     n = 2'd1;
                  end
               end
               sst_pkg::MODE_STRING: begin
                  if (c == "\"") begin
                     t[0] = mk(sst_pkg::KIND_STR, sst_pkg::ERR_NONE, tstart_ff + PW'(1),
                               p - tstart_ff - PW'(1), tline_ff, tcol_ff);
                     n = 2'd1;
                     mode_in = sst_pkg::MODE_IDLE;
                  end
               end
               sst_pkg::MODE_OPER: begin
                  pk = 6'd0;
                  unique case (op_ff)
                     sst_pkg::OP_MINUS: if (c == ">") pk = sst_pkg::KIND_ARROW;
                     sst_pkg::OP_EQ:    if (c == "=") pk = sst_pkg::KIND_EQEQ;
                     sst_pkg::OP_BANG:  if (c == "=") pk = sst_pkg::KIND_NE;
                     sst_pkg::OP_LT:    if (c == "=") pk = sst_pkg::KIND_LE;
                     sst_pkg::OP_GT:    if (c == "=") pk = sst_pkg::KIND_GE;
                     sst_pkg::OP_COLON: begin
                        if (c == ":") pk = sst_pkg::KIND_SCOPE;
                        else if (c == "=") pk = sst_pkg::KIND_DEFINE;
                     end
                     default: pk = 6'd0;
                  endcase
                  if (pk != 6'd0) begin
                     t[0] = mk(pk, sst_pkg::ERR_NONE, tstart_ff, p + PW'(1) - tstart_ff,
                               tline_ff, tcol_ff);
                     n = 2'd1;
                     mode_in = sst_pkg::MODE_IDLE;
                     op_in = sst_pkg::OP_NONE;
                  end else if (op_ff == sst_pkg::OP_BANG) begin
                     // A lone bang is an error and swallows this byte.
                     t[0] = mk(6'd0, sst_pkg::ERR_INVALID, tstart_ff, PW'(1), tline_ff,
                               tcol_ff);
                     n = 2'd1;
                     mode_in = sst_pkg::MODE_ERROR;
                     op_in = sst_pkg::OP_NONE;
                  end else begin
                     rescan = 1'b1;
                     t[0] = mk(opk, sst_pkg::ERR_NONE, tstart_ff, p - tstart_ff,
                               tline_ff, tcol_ff);
                     n = 2'd1;
                  end
               end
               default: rescan = 1'b1;
            endcase
            // Start a new token at this byte.
            if (rescan) begin
               mode_in = sst_pkg::MODE_IDLE;
               op_in = sst_pkg::OP_NONE;
               tstart_in = p;
               tline_in = line_ff;
               tcol_in = col_ff;
               single = 6'd0;
               sop = sst_pkg::OP_NONE;
               case (c)
                  "+": single = sst_pkg::KIND_PLUS;
                  "*": single = sst_pkg::KIND_STAR;
                  "/": single = sst_pkg::KIND_SLASH;
                  "(": single = sst_pkg::KIND_LPAREN;
                  ")": single = sst_pkg::KIND_RPAREN;
                  "{": single = sst_pkg::KIND_LBRACE;
                  "}": single = sst_pkg::KIND_RBRACE;
                  "[": single = sst_pkg::KIND_LBRACK;
                  "]": single = sst_pkg::KIND_RBRACK;
                  ",": single = sst_pkg::KIND_COMMA;
                  ".": single = sst_pkg::KIND_DOT;
                  "?": single = sst_pkg::KIND_QUEST;
                  "-": sop = sst_pkg::OP_MINUS;
                  "=": sop = sst_pkg::OP_EQ;
                  "!": sop = sst_pkg::OP_BANG;
                  "<": sop = sst_pkg::OP_LT;
                  ">": sop = sst_pkg::OP_GT;
                  ":": sop = sst_pkg::OP_COLON;
                  default: sop = sst_pkg::OP_NONE;
               endcase
               if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
                  mode_in = sst_pkg::MODE_IDLE;
               end else if (is_alpha(c) || c == "_") begin
                  mode_in = sst_pkg::MODE_IDENT;
                  cand_in = kw_next('1, 4'd0, c);
                  idlen_in = 4'd1;
               end else if (is_numeral(c)) begin
                  mode_in = sst_pkg::MODE_INT;
               end else if (c == "\"") begin
                  mode_in = sst_pkg::MODE_STRING;
               end else if (single != 6'd0) begin
                  t[n] = mk(single, sst_pkg::ERR_NONE, p, PW'(1), line_ff, col_ff);
                  n = n + 2'd1;
               end else if (sop != sst_pkg::OP_NONE) begin
                  mode_in = sst_pkg::MODE_OPER;
                  op_in = sop;
               end else begin
                  t[n] = mk(6'd0, sst_pkg::ERR_INVALID, p, PW'(1), line_ff, col_ff);
                  n = n + 2'd1;
                  mode_in = sst_pkg::MODE_ERROR;
               end
            end
            if (mode_in != sst_pkg::MODE_ERROR) begin
               pos_in = pos_ff + CW'(1);
               if (c == "\n") begin
                  line_in = line_ff + PW'(1);
                  col_in = PW'(1);
               end else begin
                  col_in = col_ff + PW'(1);
               end
            end
         end
         if (n != 2'd0) begin
            t[n - 2'd1].last_of_run = 1'b1;
         end
      end
   end

   assign grp_tok = t;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sst_pkg::MODE_IDLE;
         op_ff <= sst_pkg::OP_NONE;
         tstart_ff <= '0;
         tline_ff <= PW'(1);
         tcol_ff <= PW'(1);
         pos_ff <= '0;
         line_ff <= PW'(1);
         col_ff <= PW'(1);
         cand_ff <= '1;
         idlen_ff <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         op_ff <= op_in;
         tstart_ff <= tstart_in;
         tline_ff <= tline_in;
         tcol_ff <= tcol_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
         col_ff <= col_in;
         cand_ff <= cand_in;
         idlen_ff <= idlen_in;
      end
   end

endmodule

// ===== rtl/sst_token_queue.sv =====
// Back part: queue of result tokens, filled a group at a time, drained one per cycle while the output is not stalled.
module sst_token_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  grp_valid,
   output logic                  grp_stall,
   input  logic [1:0]            grp_count,
   input  sst_pkg::token_type    grp_tok [3],
   output logic                  out_valid,
   input  logic                  out_stall,
   output sst_pkg::token_type    out_tok
);

   localparam int Depth = 4;

   sst_pkg::token_type mem_ff [Depth];
   logic [1:0] rd_ff, rd_in;
   logic [1:0] wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic pop, push;

   assign out_valid = cnt_ff != 3'd0;
   assign out_tok = mem_ff[rd_ff];
   assign pop = out_valid && !out_stall;
   // Room for a full group of three is kept before a new byte is taken.
   assign grp_stall = cnt_ff > 3'd1;
   assign push = grp_valid && !grp_stall;

   always_comb begin
      rd_in = rd_ff + 2'(pop);
      wr_in = wr_ff + (push ? grp_count : 2'd0);
      cnt_in = cnt_ff - 3'(pop) + (push ? 3'(grp_count) : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < grp_count) begin
               mem_ff[wr_ff + 2'(i)] <= grp_tok[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
